[rtl/core/clg_pkg.sv]
// ----------------------------------------------------------------------------
// Circle layout loss gradient package
// Shared widths, limits, command structs and the sequencer state encoding.
// ----------------------------------------------------------------------------
package clg_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int RAD_W           = 15;
    localparam int TGT_W           = 17;
    localparam int RSUM_W          = RAD_W + 1;
    localparam int T2_W            = 2 * TGT_W;

    localparam int LIMB_W          = 24;
    localparam int PROD_W          = 2 * LIMB_W;
    localparam int MACC_W          = 4 * LIMB_W;

    localparam int SUM_W           = 64;
    localparam int LOSS_W          = SUM_W - 1;
    localparam int FRAC_SHIFT      = 16;
    localparam int LOSS_LIM        = SUM_W - 1 + FRAC_SHIFT;
    localparam int GRAD_LIM        = SUM_W - 3;

    localparam logic [SUM_W-1:0] POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] NEG_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        SH_0,
        SH_1,
        SH_2
    } t_shift;

    typedef struct packed {
        logic              vld;
        logic              clr;
        t_shift            shift;
        logic [LIMB_W-1:0] a;
        logic [LIMB_W-1:0] b;
    } t_mac_cmd;

    typedef enum logic [1:0] {
        ACC_LOSS,
        ACC_GX,
        ACC_GY,
        ACC_GZ
    } t_acc_sel;

    typedef struct packed {
        logic     add;
        t_acc_sel sel;
        logic     e_neg;
        logic     d_neg;
        logic     emit;
    } t_acc_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_RS2,
        ST_RD2,
        ST_T2,
        ST_WAIT_RD2,
        ST_WAIT_T2,
        ST_EVAL,
        ST_LS_00,
        ST_LS_01,
        ST_LS_10,
        ST_LS_11,
        ST_GX_0,
        ST_GX_1,
        ST_GY_0,
        ST_GY_1,
        ST_GZ_0,
        ST_GZ_1,
        ST_DRAIN,
        ST_ADD_GZ,
        ST_EMIT
    } t_state;

endpackage

[rtl/core/clg_if.sv]
// ----------------------------------------------------------------------------
// Circle layout loss gradient channels
// Valid/ready channels for circle pairs in and row sums out.
// ----------------------------------------------------------------------------
interface clg_in_if
    import clg_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] self_x;
    logic signed [COORD_WIDTH-1:0] self_y;
    logic signed [COORD_WIDTH-1:0] self_z;
    logic signed [COORD_WIDTH-1:0] other_x;
    logic signed [COORD_WIDTH-1:0] other_y;
    logic signed [COORD_WIDTH-1:0] other_z;
    logic        [RAD_W-1:0]       self_radius;
    logic        [RAD_W-1:0]       other_radius;
    logic        [TGT_W-1:0]       target_dist;
    logic                          last_pair;

    modport source (
        output valid, self_x, self_y, self_z, other_x, other_y, other_z,
               self_radius, other_radius, target_dist, last_pair,
        input  ready
    );

    modport sink (
        input  valid, self_x, self_y, self_z, other_x, other_y, other_z,
               self_radius, other_radius, target_dist, last_pair,
        output ready
    );
endinterface

interface clg_out_if
    import clg_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic        [LOSS_W-1:0] loss_sum;
    logic signed [SUM_W-1:0]  grad_x;
    logic signed [SUM_W-1:0]  grad_y;
    logic signed [SUM_W-1:0]  grad_z;
    logic                     saturated;

    modport source (
        output valid, loss_sum, grad_x, grad_y, grad_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, loss_sum, grad_x, grad_y, grad_z, saturated,
        output ready
    );
endinterface

[rtl/core/clg_mac.sv]
// ----------------------------------------------------------------------------
// Circle layout loss gradient shared multiplier
// Registered 24x24 multiplier followed by a limb-shifted accumulator.
// ----------------------------------------------------------------------------
module clg_mac
    import clg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_cmd          i_cmd,
    output logic [MACC_W-1:0] o_acc
);

    logic [PROD_W-1:0] r_prod;
    logic              r_vld;
    logic              r_clr;
    t_shift            r_shift;
    logic [MACC_W-1:0] r_acc;
    logic [MACC_W-1:0] w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_cmd.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= PROD_W'(i_cmd.a) * PROD_W'(i_cmd.b);
        r_clr   <= i_cmd.clr;
        r_shift <= i_cmd.shift;
    end

    always_comb begin
        case (r_shift)
            SH_0:    w_term = MACC_W'(r_prod);
            SH_1:    w_term = MACC_W'(r_prod) << LIMB_W;
            SH_2:    w_term = MACC_W'(r_prod) << (2 * LIMB_W);
            default: w_term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_acc <= (r_clr ? '0 : r_acc) + w_term;
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/core/clg_accum.sv]
// ----------------------------------------------------------------------------
// Circle layout loss gradient row accumulators
// Term scaling and clipping, one shared saturating adder and the result beat.
// ----------------------------------------------------------------------------
module clg_accum
    import clg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_acc_cmd          i_cmd,
    input  logic [MACC_W-1:0] i_macc,
    output logic              o_busy,
    clg_out_if.source         o_out
);

    logic [SUM_W-1:0]  r_loss;
    logic [SUM_W-1:0]  r_gx;
    logic [SUM_W-1:0]  r_gy;
    logic [SUM_W-1:0]  r_gz;
    logic              r_clip;
    logic              r_out_valid;
    logic [LOSS_W-1:0] r_o_loss;
    logic [SUM_W-1:0]  r_o_gx;
    logic [SUM_W-1:0]  r_o_gy;
    logic [SUM_W-1:0]  r_o_gz;
    logic              r_o_sat;

    logic              w_loss_clip;
    logic [SUM_W-1:0]  w_loss_term;
    logic              w_grad_clip;
    logic              w_grad_neg;
    logic [SUM_W-1:0]  w_grad_mag;
    logic [SUM_W-1:0]  w_grad_term;
    logic              w_term_clip;
    logic [SUM_W-1:0]  w_term;
    logic [SUM_W-1:0]  w_opnd;
    logic [SUM_W-1:0]  w_sum;
    logic              w_ovf;
    logic [SUM_W-1:0]  w_res;

    assign w_loss_clip = |i_macc[MACC_W-1:LOSS_LIM];
    assign w_loss_term = w_loss_clip ? POS_MAX : SUM_W'(i_macc[LOSS_LIM-1:FRAC_SHIFT]);

    assign w_grad_clip = |i_macc[MACC_W-1:GRAD_LIM];
    assign w_grad_neg  = i_cmd.e_neg ^ i_cmd.d_neg;
    assign w_grad_mag  = {1'b0, i_macc[GRAD_LIM-1:0], 2'b00};

    always_comb begin
        if (w_grad_clip) begin
            w_grad_term = w_grad_neg ? NEG_MIN : POS_MAX;
        end else begin
            w_grad_term = w_grad_neg ? (SUM_W'(0) - w_grad_mag) : w_grad_mag;
        end
    end

    always_comb begin
        case (i_cmd.sel)
            ACC_LOSS: w_opnd = r_loss;
            ACC_GX:   w_opnd = r_gx;
            ACC_GY:   w_opnd = r_gy;
            ACC_GZ:   w_opnd = r_gz;
            default:  w_opnd = r_loss;
        endcase
    end

    assign w_term      = (i_cmd.sel == ACC_LOSS) ? w_loss_term : w_grad_term;
    assign w_term_clip = (i_cmd.sel == ACC_LOSS) ? w_loss_clip : w_grad_clip;

    // Signed saturation also covers the loss, which stays within the positive half.
    assign w_sum = w_opnd + w_term;
    assign w_ovf = (w_opnd[SUM_W-1] == w_term[SUM_W-1]) &&
                   (w_sum[SUM_W-1] != w_opnd[SUM_W-1]);
    assign w_res = w_ovf ? (w_opnd[SUM_W-1] ? NEG_MIN : POS_MAX) : w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss <= '0;
            r_gx   <= '0;
            r_gy   <= '0;
            r_gz   <= '0;
            r_clip <= 1'b0;
        end else if (i_cmd.emit) begin
            r_loss <= '0;
            r_gx   <= '0;
            r_gy   <= '0;
            r_gz   <= '0;
            r_clip <= 1'b0;
        end else if (i_cmd.add) begin
            case (i_cmd.sel)
                ACC_LOSS: r_loss <= w_res;
                ACC_GX:   r_gx   <= w_res;
                ACC_GY:   r_gy   <= w_res;
                ACC_GZ:   r_gz   <= w_res;
                default:  r_loss <= r_loss;
            endcase
            r_clip <= r_clip | w_term_clip | w_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_loss <= r_loss[LOSS_W-1:0];
            r_o_gx   <= r_gx;
            r_o_gy   <= r_gy;
            r_o_gz   <= r_gz;
            r_o_sat  <= r_clip;
        end
    end

    assign o_busy          = r_out_valid && !o_out.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.loss_sum  = r_o_loss;
    assign o_out.grad_x    = r_o_gx;
    assign o_out.grad_y    = r_o_gy;
    assign o_out.grad_z    = r_o_gz;
    assign o_out.saturated = r_o_sat;

endmodule

[rtl/core/clg_seq.sv]
// ----------------------------------------------------------------------------
// Circle layout loss gradient sequencer
// Captures a pair, schedules the shared multiplier and decides the skip test.
// ----------------------------------------------------------------------------
module clg_seq
    import clg_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_three_d,
    input  logic [MACC_W-1:0] i_macc,
    input  logic              i_out_busy,
    output t_mac_cmd          o_mac,
    output t_acc_cmd          o_acc,
    clg_in_if.sink            i_in
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int X2W = 2 * COORD_WIDTH + 2;
    localparam int EW  = (X2W > T2_W) ? X2W : T2_W;

    t_state              r_state;
    t_state              n_state;

    logic [DW-1:0]       r_ax;
    logic [DW-1:0]       r_ay;
    logic [DW-1:0]       r_az;
    logic                r_dxn;
    logic                r_dyn;
    logic                r_dzn;
    logic [RSUM_W-1:0]   r_rsum;
    logic [RAD_W-1:0]    r_rdif;
    logic [TGT_W-1:0]    r_t;
    logic                r_last;
    logic                r_use_z;
    logic [X2W-1:0]      r_x2;
    logic [2*RSUM_W-1:0] r_rs2;
    logic [2*RAD_W-1:0]  r_rd2;
    logic [T2_W-1:0]     r_t2;
    logic [EW-1:0]       r_e;
    logic                r_e_neg;

    logic                w_accept;
    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic signed [DW-1:0] w_dz;
    logic [DW-1:0]       w_az;
    logic                w_skip;
    logic                w_e_neg;
    logic [EW-1:0]       w_e;
    logic [PROD_W-1:0]   w_e_ext;
    logic [LIMB_W-1:0]   w_e0;
    logic [LIMB_W-1:0]   w_e1;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && (r_state == ST_IDLE);

    assign w_dx = {i_in.self_x[COORD_WIDTH-1], i_in.self_x} -
                  {i_in.other_x[COORD_WIDTH-1], i_in.other_x};
    assign w_dy = {i_in.self_y[COORD_WIDTH-1], i_in.self_y} -
                  {i_in.other_y[COORD_WIDTH-1], i_in.other_y};
    assign w_dz = {i_in.self_z[COORD_WIDTH-1], i_in.self_z} -
                  {i_in.other_z[COORD_WIDTH-1], i_in.other_z};
    assign w_az = w_dz[DW-1] ? DW'(-w_dz) : DW'(w_dz);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax    <= w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
            r_ay    <= w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
            r_az    <= i_three_d ? w_az : '0;
            r_dxn   <= w_dx[DW-1];
            r_dyn   <= w_dy[DW-1];
            r_dzn   <= w_dz[DW-1];
            r_rsum  <= RSUM_W'(i_in.self_radius) + RSUM_W'(i_in.other_radius);
            r_rdif  <= (i_in.self_radius > i_in.other_radius) ?
                       (i_in.self_radius - i_in.other_radius) :
                       (i_in.other_radius - i_in.self_radius);
            r_t     <= i_in.target_dist;
            r_last  <= i_in.last_pair;
            r_use_z <= i_three_d;
        end
        if (r_state == ST_RD2) begin
            r_x2 <= i_macc[X2W-1:0];
        end
        if (r_state == ST_T2) begin
            r_rs2 <= i_macc[2*RSUM_W-1:0];
        end
        if (r_state == ST_WAIT_RD2) begin
            r_rd2 <= i_macc[2*RAD_W-1:0];
        end
        if (r_state == ST_WAIT_T2) begin
            r_t2 <= i_macc[T2_W-1:0];
        end
        if (r_state == ST_EVAL) begin
            r_e     <= w_e;
            r_e_neg <= w_e_neg;
        end
    end

    // Centre distance is compared through its square, the target directly.
    assign w_skip  = ((RSUM_W+1)'(r_t) >= (RSUM_W+1)'(r_rsum) && EW'(r_x2) >= EW'(r_rs2)) ||
                     (r_t <= TGT_W'(r_rdif) && EW'(r_x2) <= EW'(r_rd2));
    assign w_e_neg = EW'(r_x2) < EW'(r_t2);
    assign w_e     = w_e_neg ? (EW'(r_t2) - EW'(r_x2)) : (EW'(r_x2) - EW'(r_t2));

    assign w_e_ext = PROD_W'(r_e);
    assign w_e0    = w_e_ext[LIMB_W-1:0];
    assign w_e1    = w_e_ext[PROD_W-1:LIMB_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_mac.vld   = 1'b0;
        o_mac.clr   = 1'b0;
        o_mac.shift = SH_0;
        o_mac.a     = '0;
        o_mac.b     = '0;
        o_acc.add   = 1'b0;
        o_acc.sel   = ACC_LOSS;
        o_acc.e_neg = r_e_neg;
        o_acc.d_neg = 1'b0;
        o_acc.emit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                o_mac.vld = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = LIMB_W'(r_ax);
                o_mac.b   = LIMB_W'(r_ax);
                n_state   = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                o_mac.vld = 1'b1;
                o_mac.a   = LIMB_W'(r_ay);
                o_mac.b   = LIMB_W'(r_ay);
                n_state   = ST_SQ_Z;
            end
            ST_SQ_Z: begin
                o_mac.vld = 1'b1;
                o_mac.a   = LIMB_W'(r_az);
                o_mac.b   = LIMB_W'(r_az);
                n_state   = ST_RS2;
            end
            ST_RS2: begin
                o_mac.vld = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = LIMB_W'(r_rsum);
                o_mac.b   = LIMB_W'(r_rsum);
                n_state   = ST_RD2;
            end
            ST_RD2: begin
                o_mac.vld = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = LIMB_W'(r_rdif);
                o_mac.b   = LIMB_W'(r_rdif);
                n_state   = ST_T2;
            end
            ST_T2: begin
                o_mac.vld = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = LIMB_W'(r_t);
                o_mac.b   = LIMB_W'(r_t);
                n_state   = ST_WAIT_RD2;
            end
            ST_WAIT_RD2: begin
                n_state = ST_WAIT_T2;
            end
            ST_WAIT_T2: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!w_skip) begin
                    n_state = ST_LS_00;
                end else if (r_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LS_00: begin
                o_mac.vld = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = w_e0;
                o_mac.b   = w_e0;
                n_state   = ST_LS_01;
            end
            ST_LS_01: begin
                o_mac.vld   = 1'b1;
                o_mac.shift = SH_1;
                o_mac.a     = w_e0;
                o_mac.b     = w_e1;
                n_state     = ST_LS_10;
            end
            ST_LS_10: begin
                o_mac.vld   = 1'b1;
                o_mac.shift = SH_1;
                o_mac.a     = w_e1;
                o_mac.b     = w_e0;
                n_state     = ST_LS_11;
            end
            ST_LS_11: begin
                o_mac.vld   = 1'b1;
                o_mac.shift = SH_2;
                o_mac.a     = w_e1;
                o_mac.b     = w_e1;
                n_state     = ST_GX_0;
            end
            ST_GX_0: begin
                o_mac.vld = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = w_e0;
                o_mac.b   = LIMB_W'(r_ax);
                n_state   = ST_GX_1;
            end
            ST_GX_1: begin
                o_mac.vld   = 1'b1;
                o_mac.shift = SH_1;
                o_mac.a     = w_e1;
                o_mac.b     = LIMB_W'(r_ax);
                o_acc.add   = 1'b1;
                o_acc.sel   = ACC_LOSS;
                n_state     = ST_GY_0;
            end
            ST_GY_0: begin
                o_mac.vld = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = w_e0;
                o_mac.b   = LIMB_W'(r_ay);
                n_state   = ST_GY_1;
            end
            ST_GY_1: begin
                o_mac.vld   = 1'b1;
                o_mac.shift = SH_1;
                o_mac.a     = w_e1;
                o_mac.b     = LIMB_W'(r_ay);
                o_acc.add   = 1'b1;
                o_acc.sel   = ACC_GX;
                o_acc.d_neg = r_dxn;
                n_state     = ST_GZ_0;
            end
            ST_GZ_0: begin
                o_mac.vld = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = w_e0;
                o_mac.b   = LIMB_W'(r_az);
                n_state   = ST_GZ_1;
            end
            ST_GZ_1: begin
                o_mac.vld   = 1'b1;
                o_mac.shift = SH_1;
                o_mac.a     = w_e1;
                o_mac.b     = LIMB_W'(r_az);
                o_acc.add   = 1'b1;
                o_acc.sel   = ACC_GY;
                o_acc.d_neg = r_dyn;
                n_state     = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_ADD_GZ;
            end
            ST_ADD_GZ: begin
                o_acc.add   = r_use_z;
                o_acc.sel   = ACC_GZ;
                o_acc.d_neg = r_dzn;
                n_state     = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!i_out_busy) begin
                    o_acc.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/circle_layout_loss_gradient.sv]
// ----------------------------------------------------------------------------
// Circle layout loss gradient
// Squared-distance loss and gradient sums over the pairs of one circle's row.
// ----------------------------------------------------------------------------
// Pairs arrive on the i_in channel as valid/ready beats and row sums leave on
// the o_out channel. The three_d register is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. One 24x24 multiplier does every product
// of a pair in turn: three squares for the centre distance, three for the
// radius and target bounds, four limb products for the loss and two for each
// gradient axis. A computed pair holds the block until its last gradient is
// added; a skipped pair leaves after the skip test. No new pair is taken
// until the block is back in idle. A pair marked last_pair then passes
// through the emit state, which moves the sums into the output register and
// raises the result beat. If the receiver stalls, the result beat holds and
// the next row may run; the following last pair waits until the output
// register is free. Reset clears the accumulators, the saturation flag, the
// mode register and the output valid.
// ----------------------------------------------------------------------------
module circle_layout_loss_gradient
    import clg_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    clg_in_if.sink    i_in,
    clg_out_if.source o_out
);

    logic              r_three_d;
    t_mac_cmd          w_mac_cmd;
    t_acc_cmd          w_acc_cmd;
    logic [MACC_W-1:0] w_macc;
    logic              w_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_d <= 1'b0;
        end else if (i_cfg_we) begin
            r_three_d <= i_cfg_wdata;
        end
    end

    clg_seq #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_three_d  (r_three_d),
        .i_macc     (w_macc),
        .i_out_busy (w_out_busy),
        .o_mac      (w_mac_cmd),
        .o_acc      (w_acc_cmd),
        .i_in       (i_in)
    );

    clg_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mac_cmd),
        .o_acc   (w_macc)
    );

    clg_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_acc_cmd),
        .i_macc  (w_macc),
        .o_busy  (w_out_busy),
        .o_out   (o_out)
    );

endmodule

[rtl/core/clg_checker.sv]
// ----------------------------------------------------------------------------
// Circle layout loss gradient checker
// Port-level assertions on the pair and result channels.
// ----------------------------------------------------------------------------
module clg_checker
    import clg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [LOSS_W-1:0] i_loss_sum,
    input  logic [SUM_W-1:0]  i_grad_x,
    input  logic [SUM_W-1:0]  i_grad_y,
    input  logic [SUM_W-1:0]  i_grad_z,
    input  logic              i_saturated
);

    // No result beat is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // An accepted pair keeps the sequencer busy, so ready stays low after the beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("pair channel ready too soon after a beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable({i_loss_sum, i_grad_x, i_grad_y, i_grad_z, i_saturated}))
        else $error("result payload changed while stalled");

endmodule

bind circle_layout_loss_gradient clg_checker u_clg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_loss_sum  (o_out.loss_sum),
    .i_grad_x    (o_out.grad_x),
    .i_grad_y    (o_out.grad_y),
    .i_grad_z    (o_out.grad_z),
    .i_saturated (o_out.saturated)
);
